FILE: design/spq_pkg.sv
// shared types and constants of the sorted priority queue
package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture operand beat
    logic commit;  // apply operation and register result
  } ctrl_t;

  typedef struct packed {
    logic               dropped;
    logic [COUNT_W-1:0] entry_count;
    logic               is_full;
    logic               is_empty;
    logic [VALUE_W-1:0] front_value;
  } result_t;

endpackage

FILE: design/sorted_priority_queue.sv
// top level of the sorted priority queue
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_tvalid_i / s_tready_o      tuser: command, tdata: value
//  m_axis   out  m_tvalid_o / m_tready_i      tdata: front, flags, count, dropped
//  cfg      in   cfg_valid_i / cfg_ready_o    cfg_data_i: order_mode
//
// each beat first has its operands captured, then all sixteen slots compare
// against the operand and shift in parallel
// the result register holds one beat; a stalled result delays the next apply
// reset clears the count and sets sorted order; slot contents need no clear
// a new input beat is taken while the previous result still waits
module sorted_priority_queue import spq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // [31:0] value
  input  logic [1:0]  s_tuser_i,   // [1:0] command
  // result beats
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o,   // [31:0] front_value, [32] is_empty, [33] is_full,
                                   // [38:34] entry_count, [39] dropped
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i   // order_mode: 1 sorted, 0 fifo
);

  ctrl_t   ctrl;
  result_t result;

  // mode register always takes a write
  assign cfg_ready_o = 1'b1;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .ctrl_o     (ctrl)
  );

  spq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .cmd_i      (s_tuser_i),
    .value_i    (s_tdata_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_mode_i (cfg_data_i),
    .result_o   (result)
  );

  // result struct is declared lowest field last, so it packs as listed above
  assign m_tdata_o = result;

endmodule

FILE: design/spq_ctrl.sv
// handshake controller of the sorted priority queue
module spq_ctrl import spq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_tvalid_i,
  output logic  s_tready_o,
  output logic  m_tvalid_o,
  input  logic  m_tready_i,
  output ctrl_t ctrl_o
);

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_e;

  state_e state_q;
  logic   m_valid_q;
  logic   out_free;

  assign out_free      = !m_valid_q || m_tready_i;
  assign s_tready_o    = (state_q == ST_IDLE);
  assign ctrl_o.load   = s_tvalid_i && (state_q == ST_IDLE);
  assign ctrl_o.commit = (state_q == ST_APPLY) && out_free;
  assign m_tvalid_o    = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i) state_q <= ST_APPLY;
          if (m_tready_i) m_valid_q <= 1'b0;
        end
        ST_APPLY: begin
          // a waiting result without ready keeps valid high
          if (out_free) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q   <= ST_IDLE;
          m_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: design/spq_datapath.sv
// slot array with parallel compare and shift, plus result register
module spq_datapath import spq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  input  logic [CMD_W-1:0]   cmd_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               cfg_we_i,
  input  logic               cfg_mode_i,
  output result_t            result_o
);

  logic [CMD_W-1:0]   cmd_q;
  logic [VALUE_W-1:0] val_q;
  logic [VALUE_W-1:0] slot_q [CAPACITY];
  logic [VALUE_W-1:0] slot_d [CAPACITY];
  logic [CNT_W-1:0]   count_q, count_d;
  logic               mode_q;
  result_t            result_q;

  logic [CAPACITY-1:0] not_smaller;  // stored slot >= operand
  logic [CAPACITY-1:0] ins_mask;     // slots at or behind the insert point
  logic                full, empty, drop;
  logic                do_enq, do_deq;
  logic                seen;

  assign full   = (count_q == CNT_W'(CAPACITY));
  assign empty  = (count_q == '0);
  assign do_enq = (cmd_q == CMD_ENQ) && !full;
  assign do_deq = (cmd_q == CMD_DEQ) && !empty;
  assign drop   = (cmd_q == CMD_ENQ) && full;

  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      not_smaller[i] = ($signed(slot_q[i]) >= $signed(val_q)) && (CNT_W'(i) < count_q);
      seen           = seen | (mode_q & not_smaller[i]);
      ins_mask[i]    = seen | (CNT_W'(i) >= count_q);
    end
  end

  always_comb begin
    count_d = count_q;
    for (int i = 0; i < CAPACITY; i++) slot_d[i] = slot_q[i];
    if (do_enq) begin
      count_d = count_q + CNT_W'(1);
      for (int i = 0; i < CAPACITY; i++) begin
        if (i == 0) begin
          if (ins_mask[0]) slot_d[0] = val_q;
        end else if (ins_mask[i]) begin
          slot_d[i] = ins_mask[i-1] ? slot_q[i-1] : val_q;
        end
      end
    end else if (do_deq) begin
      count_d = count_q - CNT_W'(1);
      for (int i = 0; i < CAPACITY - 1; i++) slot_d[i] = slot_q[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mode_q  <= 1'b1;
    end else begin
      if (cfg_we_i) mode_q <= cfg_mode_i;
      if (ctrl_i.commit) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_i;
      val_q <= value_i;
    end
    if (ctrl_i.commit) begin
      for (int i = 0; i < CAPACITY; i++) slot_q[i] <= slot_d[i];
      result_q.front_value <= (count_d != '0) ? slot_d[0] : '0;
      result_q.is_empty    <= (count_d == '0);
      result_q.is_full     <= (count_d == CNT_W'(CAPACITY));
      result_q.entry_count <= COUNT_W'(count_d);
      result_q.dropped     <= drop;
    end
  end

  assign result_o = result_q;

endmodule

FILE: test/spq_checker.sv
// checker for the sorted priority queue: mirrors the queue, predicts and compares result beats
`timescale 1ns / 1ps

module spq_checker import spq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,   // [31:0] value
  input  logic [1:0]  s_tuser_i,   // [1:0] command
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,   // [31:0] front_value, [32] is_empty, [33] is_full,
                                   // [38:34] entry_count, [39] dropped
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int PRINT_CAP = 40;

  // mirror of the queue contents and the order register
  logic signed [VALUE_W-1:0] mirror_slots [CAPACITY];
  int unsigned               mirror_count;
  logic                      mirror_sorted;

  result_t status_due [$];
  int      mismatches;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // apply one command to the mirror and return the status it should report
  function automatic result_t apply_queue_op(input logic [1:0] cmd,
                                             input logic signed [VALUE_W-1:0] val);
    result_t     status;
    int unsigned pos;
    bit          found;
    status.dropped = 1'b0;
    if (cmd == CMD_ENQ) begin
      if (mirror_count >= CAPACITY) begin
        status.dropped = 1'b1;
      end else begin
        pos   = mirror_count;
        found = 1'b0;
        // sorted order: ahead of the first entry that is not smaller
        if (mirror_sorted)
          for (int i = 0; i < mirror_count; i++)
            if (!found && val <= mirror_slots[i]) begin
              pos   = i;
              found = 1'b1;
            end
        for (int i = mirror_count; i > pos; i--)
          mirror_slots[i] = mirror_slots[i-1];
        mirror_slots[pos] = val;
        mirror_count++;
      end
    end else if (cmd == CMD_DEQ) begin
      if (mirror_count > 0) begin
        for (int i = 1; i < mirror_count; i++)
          mirror_slots[i-1] = mirror_slots[i];
        mirror_count--;
      end
    end
    // any other code only queries
    status.front_value = (mirror_count > 0) ? mirror_slots[0] : '0;
    status.is_empty    = (mirror_count == 0);
    status.is_full     = (mirror_count == CAPACITY);
    status.entry_count = COUNT_W'(mirror_count);
    return status;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      status_due.delete();
      mirror_count  = 0;
      mirror_sorted = 1'b1;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i)
        mirror_sorted = cfg_data_i;
      if (s_tvalid_i && s_tready_i)
        status_due.push_back(apply_queue_op(s_tuser_i, s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        got = result_t'(m_tdata_i);
        if (status_due.size() == 0) begin
          report_mismatch("unexpected result beat", got.front_value, '0);
        end else begin
          want = status_due.pop_front();
          if (got.front_value !== want.front_value)
            report_mismatch("front_value", got.front_value, want.front_value);
          if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
          if (got.is_full !== want.is_full)
            report_mismatch("is_full", 32'(got.is_full), 32'(want.is_full));
          if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
          if (got.dropped !== want.dropped)
            report_mismatch("dropped", 32'(got.dropped), 32'(want.dropped));
        end
      end
      pending_o <= status_due.size();
    end
  end

endmodule

FILE: test/testbench.sv
// stimulus and verdict for the sorted priority queue
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam logic [1:0] CMD_RESERVED = 2'd3;   // unused code, acts as a query
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         PHASES       = 14;
  localparam int         PHASE_BEATS  = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [31:0] s_tdata_i;   // [31:0] value
  logic [1:0]  s_tuser_i;   // [1:0] command
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [39:0] m_tdata_o;   // [31:0] front_value, [32] is_empty, [33] is_full,
                            // [38:34] entry_count, [39] dropped
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_data_i;

  int fail_count;
  int pending;
  int cycle_count;

  // idling controls for the input sender and the result sink
  bit sender_gaps;
  bit sink_gaps;
  bit hold_results;

  always #2 clk_i = ~clk_i;

  sorted_priority_queue u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  spq_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid_i),
    .s_tready_i   (s_tready_o),
    .s_tdata_i    (s_tdata_i),
    .s_tuser_i    (s_tuser_i),
    .m_tvalid_i   (m_tvalid_o),
    .m_tready_i   (m_tready_i),
    .m_tdata_i    (m_tdata_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // one input beat; valid stays high across back-to-back beats
  task automatic send_beat(input logic [1:0] cmd, input logic [31:0] val);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= cmd;
    s_tdata_i  <= val;
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  // stop offering beats until every result beat has come back
  task automatic drain_results();
    s_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // order register write, only with the queue idle
  task automatic set_order_mode(input logic sorted);
    drain_results();
    // let any trailing apply work settle
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= sorted;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // values: full range, tight cluster for ties, the signed extremes and a small signed range
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return 32'($urandom_range(0, 8)) - 32'd4;
      2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(0, 255)) - 32'd128;
    endcase
  endfunction

  function automatic logic [1:0] pick_command(input int enq_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < enq_pct) return CMD_ENQ;
    r = $urandom_range(0, 9);
    if (r < 7) return CMD_DEQ;
    if (r < 9) return CMD_QUERY;
    return CMD_RESERVED;
  endfunction

  // result sink: random stalls per beat, plus one long hold-off on request
  initial begin
    int stall;
    m_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_results) begin
        m_tready_i <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk_i);
        hold_results = 1'b0;
      end
      stall = sink_gaps ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        m_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // main stimulus
  initial begin
    logic [31:0] fill_values [16];
    int          enq_pct;
    rst_ni       = 1'b0;
    s_tvalid_i   = 1'b0;
    s_tdata_i    = '0;
    s_tuser_i    = CMD_QUERY;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = 1'b1;
    sender_gaps  = 1'b1;
    sink_gaps    = 1'b1;
    hold_results = 1'b0;
    fill_values  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                     32'h1, 32'h5, 32'h5, 32'hFFFF_FFFB,
                     32'h5555_5555, 32'hAAAA_AAAA, 32'h3, 32'h2,
                     32'd100, 32'hFFFF_FF9C, 32'h7, 32'h7};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue, sorted fill with extremes and ties, overflow
    send_beat(CMD_DEQ, 32'h0);          // dequeue while empty is ignored
    send_beat(CMD_QUERY, 32'hFFFF_FFFF);
    send_beat(CMD_RESERVED, 32'h0);     // unused code behaves as a query
    foreach (fill_values[i])
      send_beat(CMD_ENQ, fill_values[i]);
    send_beat(CMD_ENQ, 32'h9);          // full, must be dropped
    send_beat(CMD_DEQ, 32'h0);
    send_beat(CMD_DEQ, 32'h0);
    send_beat(CMD_QUERY, 32'h0);
    // switch to fifo with entries stored: old order stays, new value at tail
    set_order_mode(1'b0);
    send_beat(CMD_ENQ, 32'hFFFF_FFF9);
    send_beat(CMD_DEQ, 32'h0);

    // random phases: fill-heavy, balanced and drain-heavy mixes in turn
    for (int p = 0; p < PHASES; p++) begin
      // each phase starts idle, so the register write is legal here
      set_order_mode(p < 2 ? p[0] : 1'($urandom_range(0, 1)));
      sender_gaps = $urandom_range(0, 1);
      sink_gaps   = $urandom_range(0, 1);
      case (p % 3)
        0:       enq_pct = 85;
        1:       enq_pct = 50;
        default: enq_pct = 20;
      endcase
      if (p == 5) begin
        // long sink hold-off while beats keep coming, queue and pipe back up
        sender_gaps  = 1'b0;
        enq_pct      = 60;
        hold_results = 1'b1;
      end
      for (int n = 0; n < PHASE_BEATS; n++)
        send_beat(pick_command(enq_pct), pick_value());
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
design/spq_pkg.sv
design/spq_ctrl.sv
design/spq_datapath.sv
design/sorted_priority_queue.sv
test/spq_checker.sv
test/testbench.sv
